[rtl/gregorian_julian_day_converter_top_macros.svh]
// Assertion macros for the Gregorian / Julian day number converter.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef GREGORIAN_JULIAN_DAY_CONVERTER_TOP_MACROS_SVH
`define GREGORIAN_JULIAN_DAY_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock while out of reset
`define GJD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen while out of reset
`define GJD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GJD_ASSERT(label, prop, msg)
`define GJD_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/gjd_pkg.sv]
// Shared types, constants and small functions of the date converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package gjd_pkg;

    // pipeline depth: datapath stages plus the output register
    localparam int DP_STAGES  = 8;
    localparam int NUM_STAGES = DP_STAGES + 1;

    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int JDN_W  = 23;
    localparam int WD_W   = 3;
    localparam int CENT_W = 7;
    localparam int YA_W   = 7;

    // command codes
    localparam logic CMD_TO_JDN  = 1'b0;
    localparam logic CMD_TO_DATE = 1'b1;

    // month numbers used in checks
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    // calendar range
    localparam logic [JDN_W-1:0]  JDN_FIRST      = 23'd2361222;
    localparam logic [JDN_W-1:0]  JDN_LAST       = 23'd5373484;
    localparam logic [JDN_W-1:0]  JDN_OFFSET     = 23'd1721119;
    localparam logic [YEAR_W-1:0] YEAR_FIRST     = 14'd1752;
    localparam logic [YEAR_W-1:0] YEAR_LAST      = 14'd9999;
    localparam logic [YEAR_W-1:0] YEAR_BASE      = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_TWO_DIGIT = 14'd99;
    localparam logic [YEAR_W-1:0] CENTURY        = 14'd100;
    localparam logic [DAY_W-1:0]  REFORM_DAY     = 5'd14;
    localparam logic [YA_W-1:0]   YA_LAST        = 7'd99;

    // cycle lengths
    localparam logic [17:0] DAYS_400Y  = 18'd146097;
    localparam logic [10:0] DAYS_4Y    = 11'd1461;
    localparam logic [7:0]  MONTH_SPAN = 8'd153;

    // reciprocals for constant division: q = (x * R) >> SH
    localparam int          RECIP_100_W    = 13;
    localparam logic [12:0] RECIP_100      = 13'd5243;
    localparam int          RECIP_100_SH   = 19;
    localparam int          RECIP_CYCLE_W  = 24;
    localparam logic [23:0] RECIP_CYCLE    = 24'd15051803;
    localparam int          RECIP_CYCLE_SH = 41;
    localparam int          RECIP_1461_W   = 22;
    localparam logic [21:0] RECIP_1461     = 22'd2939745;
    localparam int          RECIP_1461_SH  = 32;
    localparam int          RECIP_153_W    = 10;
    localparam logic [9:0]  RECIP_153      = 10'd857;
    localparam int          RECIP_153_SH   = 17;
    localparam logic [7:0]  RECIP_5        = 8'd205;
    localparam int          RECIP_5_SH     = 10;

    typedef struct packed {
        logic              cmd;
        logic [YEAR_W-1:0] year_in;
        logic [MON_W-1:0]  month_in;
        logic [DAY_W-1:0]  day_in;
        logic [JDN_W-1:0]  day_number_in;
    } item_t;

    typedef struct packed {
        logic [JDN_W-1:0]  day_number_out;
        logic [YEAR_W-1:0] year_out;
        logic [MON_W-1:0]  month_out;
        logic [DAY_W-1:0]  day_out;
        logic [WD_W-1:0]   weekday;
        logic [DAY_W-1:0]  month_length;
        logic              leap;
        logic              valid_res;
    } result_t;

    // per-stage load enables and valid bits
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] live;
    } stage_ctrl_t;

    // Gregorian leap year from century and year within century
    function automatic logic leap_of(input logic [CENT_W-1:0] c, input logic [YA_W-1:0] ya);
        return (ya == '0) ? (c[1:0] == 2'b00) : (ya[1:0] == 2'b00);
    endfunction

    // days in month; zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic lp);
        logic [DAY_W-1:0] len;
        if (m == MON_FEB)
            len = lp ? 5'd29 : 5'd28;
        else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            len = 5'd30;
        else if (m inside {[4'd1:4'd12]})
            len = 5'd31;
        else
            len = 5'd0;
        return len;
    endfunction

    // (153 * m + 2) / 5 for a March-based month index
    function automatic logic [8:0] month_offset(input logic [MON_W-1:0] ms);
        logic [8:0] ofs;
        case (ms)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

    // value mod 7 by summing octal digits (8 = 1 mod 7)
    function automatic logic [WD_W-1:0] mod7(input logic [JDN_W-1:0] v);
        logic [JDN_W:0] w;
        logic [5:0]     s1;
        logic [3:0]     s2;
        logic [2:0]     s3;
        w  = {1'b0, v};
        s1 = '0;
        for (int i = 0; i < (JDN_W + 1) / 3; i++)
            s1 = s1 + 6'(w[3*i +: 3]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 3'(s2[3]) + s2[2:0];
        return (s3 == 3'd7) ? 3'd0 : s3;
    endfunction

endpackage

`default_nettype wire

[rtl/gjd_pipe_ctrl.sv]
// Valid bits and stage load enables of the converter pipeline.
// Uses gjd_pkg; instantiated by the top level.
`default_nettype none

module gjd_pipe_ctrl import gjd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    output logic        result_valid,
    input  logic        result_stall,
    output stage_ctrl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !result_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? item_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign item_stall   = !ready[0];
    assign result_valid = valid_reg[NUM_STAGES-1];
    assign ctl.en       = ready;
    assign ctl.live     = valid_reg;

endmodule

`default_nettype wire

[rtl/gjd_date_to_jdn.sv]
// Date to day number datapath: checks a Gregorian date and converts it.
// Uses gjd_pkg; eight stages loaded by the shared enables.
`default_nettype none

module gjd_date_to_jdn import gjd_pkg::*; (
    input  logic                 clk,
    input  logic [DP_STAGES-1:0] en,
    input  item_t                item,
    output result_t              res
);

    localparam int C_PROD_W  = YEAR_W + RECIP_100_W;
    localparam int TC_PROD_W = 25;
    localparam int TY_PROD_W = 18;

    // date fields carried alongside the arithmetic
    typedef struct packed {
        logic              ok;
        logic              lp;
        logic [DAY_W-1:0]  ml;
        logic [YEAR_W-1:0] y;
        logic [MON_W-1:0]  m;
        logic [DAY_W-1:0]  d;
    } date_carry_t;

    // stage 0
    logic [YEAR_W-1:0] y0_reg, y0_next;
    logic [MON_W-1:0]  m0_reg;
    logic [DAY_W-1:0]  d0_reg;
    logic              yok0_reg, yok0_next;
    logic              two_digit, early;
    // stage 1
    logic [C_PROD_W-1:0] c_prod;
    logic [CENT_W-1:0]   c1_reg, c1_next;
    logic [YEAR_W-1:0]   y1_reg;
    logic [MON_W-1:0]    m1_reg;
    logic [DAY_W-1:0]    d1_reg;
    logic                yok1_reg;
    // stage 2
    logic [YA_W-1:0]   ya;
    logic [CENT_W-1:0] cs2_reg, cs2_next;
    logic [YA_W-1:0]   yas2_reg, yas2_next;
    logic [MON_W-1:0]  ms2_reg, ms2_next;
    date_carry_t       cr2_reg, cr2_next;
    // stage 3
    logic [TC_PROD_W-1:0] tc_prod;
    logic [TY_PROD_W-1:0] ty_prod;
    logic [JDN_W-1:0]     tc3_reg;
    logic [15:0]          ty3_reg;
    logic [8:0]           tm3_reg;
    date_carry_t          cr3_reg;
    // stage 4..6
    logic [JDN_W-1:0] jd4_reg, jd4_next;
    date_carry_t      cr4_reg;
    logic [JDN_W-1:0] jd5_reg;
    logic [WD_W-1:0]  wd5_reg;
    date_carry_t      cr5_reg;
    logic [JDN_W-1:0] jd6_reg;
    logic [WD_W-1:0]  wd6_reg;
    date_carry_t      cr6_reg;
    // stage 7
    result_t res_reg, res_next;

    // stage 0: two-digit year fold and year range check
    always_comb
    begin
        two_digit = item.year_in <= YEAR_TWO_DIGIT;
        y0_next   = two_digit ? item.year_in + YEAR_BASE : item.year_in;
        early     = (item.year_in < YEAR_FIRST) || (item.year_in > YEAR_LAST) ||
                    ((item.year_in == YEAR_FIRST) &&
                     ((item.month_in < MON_SEP) ||
                      ((item.month_in == MON_SEP) && (item.day_in < REFORM_DAY))));
        yok0_next = two_digit || !early;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y0_reg   <= y0_next;
            m0_reg   <= item.month_in;
            d0_reg   <= item.day_in;
            yok0_reg <= yok0_next;
        end
    end

    // stage 1: century = year / 100
    always_comb
    begin
        c_prod  = C_PROD_W'(y0_reg) * C_PROD_W'(RECIP_100);
        c1_next = c_prod[RECIP_100_SH +: CENT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c1_reg   <= c1_next;
            y1_reg   <= y0_reg;
            m1_reg   <= m0_reg;
            d1_reg   <= d0_reg;
            yok1_reg <= yok0_reg;
        end
    end

    // stage 2: leap, month length, date check, shift to a March-based year
    always_comb
    begin
        ya          = YA_W'(y1_reg - YEAR_W'(c1_reg) * CENTURY);
        cr2_next.lp = leap_of(c1_reg, ya);
        cr2_next.ml = month_len(m1_reg, cr2_next.lp);
        cr2_next.ok = yok1_reg && (d1_reg != '0) && (m1_reg != '0) &&
                      (m1_reg <= MON_DEC) && (d1_reg <= cr2_next.ml);
        cr2_next.y  = y1_reg;
        cr2_next.m  = m1_reg;
        cr2_next.d  = d1_reg;
        if (m1_reg <= MON_FEB)
        begin
            // January and February count in the previous year
            ms2_next = m1_reg + 4'd9;
            if (ya == '0)
            begin
                cs2_next  = c1_reg - 7'd1;
                yas2_next = YA_LAST;
            end
            else
            begin
                cs2_next  = c1_reg;
                yas2_next = ya - 7'd1;
            end
        end
        else
        begin
            ms2_next  = m1_reg - 4'd3;
            cs2_next  = c1_reg;
            yas2_next = ya;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            cs2_reg  <= cs2_next;
            yas2_reg <= yas2_next;
            ms2_reg  <= ms2_next;
            cr2_reg  <= cr2_next;
        end
    end

    // stage 3: day counts of whole centuries, years and months
    always_comb
    begin
        tc_prod = TC_PROD_W'(cs2_reg) * TC_PROD_W'(DAYS_400Y);
        ty_prod = TY_PROD_W'(yas2_reg) * TY_PROD_W'(DAYS_4Y);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            tc3_reg <= tc_prod[TC_PROD_W-1:2];
            ty3_reg <= ty_prod[TY_PROD_W-1:2];
            tm3_reg <= month_offset(ms2_reg);
            cr3_reg <= cr2_reg;
        end
    end

    // stage 4: sum into the day number
    assign jd4_next = tc3_reg + JDN_W'(ty3_reg) + JDN_W'(tm3_reg) +
                      JDN_W'(cr3_reg.d) + JDN_OFFSET;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            jd4_reg <= jd4_next;
            cr4_reg <= cr3_reg;
        end
    end

    // stage 5: weekday
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            jd5_reg <= jd4_reg;
            wd5_reg <= mod7(jd4_reg) + 3'd1;
            cr5_reg <= cr4_reg;
        end
    end

    // stage 6: alignment with the day-number path
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            jd6_reg <= jd5_reg;
            wd6_reg <= wd5_reg;
            cr6_reg <= cr5_reg;
        end
    end

    // stage 7: result, all zero when the date is rejected
    always_comb
    begin
        res_next = '0;
        if (cr6_reg.ok)
        begin
            res_next.day_number_out = jd6_reg;
            res_next.year_out       = cr6_reg.y;
            res_next.month_out      = cr6_reg.m;
            res_next.day_out        = cr6_reg.d;
            res_next.weekday        = wd6_reg;
            res_next.month_length   = cr6_reg.ml;
            res_next.leap           = cr6_reg.lp;
            res_next.valid_res      = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[rtl/gjd_jdn_to_date.sv]
// Day number to date datapath: range check and Gregorian date recovery.
// Uses gjd_pkg; eight stages loaded by the shared enables.
`default_nettype none

module gjd_jdn_to_date import gjd_pkg::*; (
    input  logic                 clk,
    input  logic [DP_STAGES-1:0] en,
    input  item_t                item,
    output result_t              res
);

    localparam int T_W        = 24;
    localparam int U_W        = 18;
    localparam int X2_W       = 11;
    localparam int X3_W       = 9;
    localparam int V_W        = 11;
    localparam int X4_W       = 8;
    localparam int CY_PROD_W  = T_W + RECIP_CYCLE_W;
    localparam int YR_PROD_W  = U_W + RECIP_1461_W;
    localparam int MM_PROD_W  = V_W + RECIP_153_W;
    localparam int D_PROD_W   = 16;

    // fields carried through every stage
    typedef struct packed {
        logic             ok;
        logic [JDN_W-1:0] jd;
        logic [WD_W-1:0]  wd;
    } jdn_carry_t;

    logic [JDN_W-1:0]     j, jm1;
    logic [T_W-1:0]       t0_reg, t0_next;
    jdn_carry_t           cr0_reg, cr0_next;
    logic [CY_PROD_W-1:0] cy_prod;
    logic [CENT_W-1:0]    cent1_reg;
    logic [T_W-1:0]       t1_reg;
    jdn_carry_t           cr1_reg;
    logic [U_W-1:0]       j2;
    logic [U_W-1:0]       u2_reg;
    logic [CENT_W-1:0]    cent2_reg;
    jdn_carry_t           cr2_reg;
    logic [YR_PROD_W-1:0] yr_prod;
    logic [YA_W-1:0]      yr3_reg;
    logic [U_W-1:0]       u3_reg;
    logic [CENT_W-1:0]    cent3_reg;
    jdn_carry_t           cr3_reg;
    logic [X2_W-1:0]      x2;
    logic [X2_W:0]        x2p;
    logic [X3_W-1:0]      x3;
    logic [V_W-1:0]       v4_reg, v4_next;
    logic [YA_W-1:0]      yr4_reg;
    logic [CENT_W-1:0]    cent4_reg;
    jdn_carry_t           cr4_reg;
    logic [MM_PROD_W-1:0] mm_prod;
    logic [MON_W-1:0]     mm5_reg;
    logic [V_W-1:0]       v5_reg;
    logic [YA_W-1:0]      yr5_reg;
    logic [CENT_W-1:0]    cent5_reg;
    jdn_carry_t           cr5_reg;
    logic                 late;
    logic [YA_W-1:0]      yy;
    logic [X4_W-1:0]      x46_reg, x46_next;
    logic [MON_W-1:0]     mon6_reg, mon6_next;
    logic [CENT_W-1:0]    c6_reg, c6_next;
    logic [YA_W-1:0]      ya6_reg, ya6_next;
    jdn_carry_t           cr6_reg;
    logic [D_PROD_W-1:0]  d_prod;
    logic                 lp7;
    result_t              res_reg, res_next;

    // stage 0: range check, weekday, t = 4 * (jd - offset) - 1
    always_comb
    begin
        j           = item.day_number_in - JDN_OFFSET;
        jm1         = j - 23'd1;
        t0_next     = {jm1[T_W-3:0], 2'b11};
        cr0_next.ok = (item.day_number_in >= JDN_FIRST) && (item.day_number_in <= JDN_LAST);
        cr0_next.jd = item.day_number_in;
        cr0_next.wd = mod7(item.day_number_in) + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t0_reg  <= t0_next;
            cr0_reg <= cr0_next;
        end
    end

    // stage 1: 400-year cycle index = t / 146097
    assign cy_prod = CY_PROD_W'(t0_reg) * CY_PROD_W'(RECIP_CYCLE);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cent1_reg <= cy_prod[RECIP_CYCLE_SH +: CENT_W];
            t1_reg    <= t0_reg;
            cr1_reg   <= cr0_reg;
        end
    end

    // stage 2: remainder within the cycle, u = 4 * (rem / 4) + 3
    assign j2 = U_W'(t1_reg - T_W'(cent1_reg) * T_W'(DAYS_400Y));

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            u2_reg    <= {j2[U_W-1:2], 2'b11};
            cent2_reg <= cent1_reg;
            cr2_reg   <= cr1_reg;
        end
    end

    // stage 3: year within century = u / 1461
    assign yr_prod = YR_PROD_W'(u2_reg) * YR_PROD_W'(RECIP_1461);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            yr3_reg   <= yr_prod[RECIP_1461_SH +: YA_W];
            u3_reg    <= u2_reg;
            cent3_reg <= cent2_reg;
            cr3_reg   <= cr2_reg;
        end
    end

    // stage 4: day of March-based year, v = 5 * x - 3
    always_comb
    begin
        x2      = X2_W'(u3_reg - U_W'(yr3_reg) * U_W'(DAYS_4Y));
        x2p     = (X2_W + 1)'(x2) + 12'd4;
        x3      = x2p[X3_W+1:2];
        v4_next = V_W'(12'(x3) * 12'd5 - 12'd3);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            v4_reg    <= v4_next;
            yr4_reg   <= yr3_reg;
            cent4_reg <= cent3_reg;
            cr4_reg   <= cr3_reg;
        end
    end

    // stage 5: March-based month = v / 153
    assign mm_prod = MM_PROD_W'(v4_reg) * MM_PROD_W'(RECIP_153);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            mm5_reg   <= mm_prod[RECIP_153_SH +: MON_W];
            v5_reg    <= v4_reg;
            yr5_reg   <= yr4_reg;
            cent5_reg <= cent4_reg;
            cr5_reg   <= cr4_reg;
        end
    end

    // stage 6: day remainder, calendar month, year split for the leap test
    always_comb
    begin
        x46_next = X4_W'(v5_reg - V_W'(mm5_reg) * V_W'(MONTH_SPAN));
        // January and February close the March-based year
        late      = mm5_reg >= 4'd10;
        mon6_next = late ? mm5_reg - 4'd9 : mm5_reg + 4'd3;
        yy        = yr5_reg + YA_W'(late);
        if (yy >= 7'd100)
        begin
            c6_next  = cent5_reg + 7'd1;
            ya6_next = yy - 7'd100;
        end
        else
        begin
            c6_next  = cent5_reg;
            ya6_next = yy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            x46_reg  <= x46_next;
            mon6_reg <= mon6_next;
            c6_reg   <= c6_next;
            ya6_reg  <= ya6_next;
            cr6_reg  <= cr5_reg;
        end
    end

    // stage 7: day = rem / 5 + 1, year, leap and month length
    always_comb
    begin
        d_prod   = D_PROD_W'(x46_reg) * D_PROD_W'(RECIP_5);
        lp7      = leap_of(c6_reg, ya6_reg);
        res_next = '0;
        if (cr6_reg.ok)
        begin
            res_next.day_number_out = cr6_reg.jd;
            res_next.year_out       = YEAR_W'(c6_reg) * CENTURY + YEAR_W'(ya6_reg);
            res_next.month_out      = mon6_reg;
            res_next.day_out        = DAY_W'(d_prod >> RECIP_5_SH) + 5'd1;
            res_next.weekday        = cr6_reg.wd;
            res_next.month_length   = month_len(mon6_reg, lp7);
            res_next.leap           = lp7;
            res_next.valid_res      = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[rtl/gregorian_julian_day_converter_top.sv]
// Nine register stages: eight datapath stages, then the output register.
// Throughput: one item per clock unless the result stalls; each stage moves when the
// next is empty or moving, so a stalled result holds only the full stages behind it.
// Reset (rst_n, async, active low) clears the stage valid bits; payload is not reset.
`default_nettype none
`include "gregorian_julian_day_converter_top_macros.svh"

module gregorian_julian_day_converter_top import gjd_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    stage_ctrl_t          ctl;
    result_t              res_date;
    result_t              res_jdn;
    logic [DP_STAGES-1:0] cmd_reg;
    result_t              result_reg;

    gjd_pipe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctl          (ctl)
    );

    gjd_date_to_jdn u_date (
        .clk  (clk),
        .en   (ctl.en[DP_STAGES-1:0]),
        .item (item),
        .res  (res_date)
    );

    gjd_jdn_to_date u_jdn (
        .clk  (clk),
        .en   (ctl.en[DP_STAGES-1:0]),
        .item (item),
        .res  (res_jdn)
    );

    // command travels with its item to pick the path at the output
    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
            cmd_reg[0] <= item.cmd;
        for (int k = 1; k < DP_STAGES; k++)
            if (ctl.en[k])
                cmd_reg[k] <= cmd_reg[k-1];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ctl.en[NUM_STAGES-1])
            result_reg <= (cmd_reg[DP_STAGES-1] == CMD_TO_DATE) ? res_jdn : res_date;
    end

    assign result = result_reg;

    // full pipe behind a stalled result must push back on the input
    `GJD_ASSERT(a_full_stalls, (&ctl.live && result_stall) |-> item_stall, "full pipe not stalled")
    // output valid only arrives from the stage before it
    `GJD_ASSERT(a_valid_flow, $rose(ctl.live[NUM_STAGES-1]) |-> $past(ctl.live[NUM_STAGES-2]), "result valid without source")
    // a valid result always lies in the supported day range with a nonzero weekday
    `GJD_ASSERT_NEVER(a_res_range, result_valid && result.valid_res && ((result.day_number_out < JDN_FIRST) || (result.day_number_out > JDN_LAST) || (result.weekday == '0)), "valid result out of range")

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for gregorian_julian_day_converter_top (date <-> day number).
// Depends on gjd_pkg and the RTL top; a built-in calendar predictor checks every result.
// Random idle and stall bursts on both channels, none in the closing part of the run.

module testbench import gjd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 930;
    localparam int QUIET_TAIL   = 120;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item_data = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_data;

    item_t   dates_to_send[$];
    result_t awaited_conversions[$];
    logic    item_taken = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    gregorian_julian_day_converter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------
    // Calendar predictor
    // ---------------------------------------------------------------
    function automatic bit is_leap_year(input longint unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint unsigned days_in_month(input longint unsigned y,
                                                      input longint unsigned m);
        longint unsigned len;
        case (m)
            2:                       len = is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:             len = 30;
            1, 3, 5, 7, 8, 10, 12:   len = 31;
            default:                 len = 0;
        endcase
        return len;
    endfunction

    function automatic result_t convert_calendar(input item_t it);
        result_t         r;
        longint unsigned y, m, d, jd, ys, mi, c, ya, j, x, cent, yr;
        bit              ok;
        r  = '0;
        y  = it.year_in;
        m  = it.month_in;
        d  = it.day_in;
        jd = it.day_number_in;
        if (it.cmd == CMD_TO_JDN)
        begin
            // two-digit years map into the 1900s and skip the reform check
            if (y <= YEAR_TWO_DIGIT)
            begin
                y  = y + YEAR_BASE;
                ok = 1'b1;
            end
            else
            begin
                ok = !(y < YEAR_FIRST || y > YEAR_LAST ||
                       (y == YEAR_FIRST && (m < MON_SEP ||
                                            (m == MON_SEP && d < REFORM_DAY))));
            end
            if (ok)
                ok = d > 0 && m >= 1 && m <= MON_DEC && d <= days_in_month(y, m);
            if (ok)
            begin
                // year starting in March puts the leap day last
                if (m > MON_FEB)
                begin
                    mi = m - 3;
                    ys = y;
                end
                else
                begin
                    mi = m + 9;
                    ys = y - 1;
                end
                c  = ys / 100;
                ya = ys % 100;
                jd = (DAYS_400Y * c) / 4 + (DAYS_4Y * ya) / 4 +
                     (MONTH_SPAN * mi + 2) / 5 + d + JDN_OFFSET;
            end
        end
        else
        begin
            ok = jd >= JDN_FIRST && jd <= JDN_LAST;
            if (ok)
            begin
                j    = 4 * (jd - JDN_OFFSET) - 1;
                cent = j / DAYS_400Y;
                x    = 4 * ((j % DAYS_400Y) / 4) + 3;
                yr   = x / DAYS_4Y;
                x    = 5 * (((x % DAYS_4Y) + 4) / 4) - 3;
                m    = x / MONTH_SPAN;
                d    = ((x % MONTH_SPAN) + 5) / 5;
                y    = 100 * cent + yr;
                if (m < 10)
                    m = m + 3;
                else
                begin
                    m = m - 9;
                    y = y + 1;
                end
            end
        end
        if (ok)
        begin
            r.day_number_out = JDN_W'(jd);
            r.year_out       = YEAR_W'(y);
            r.month_out      = MON_W'(m);
            r.day_out        = DAY_W'(d);
            r.weekday        = WD_W'(jd % 7 + 1);
            r.month_length   = DAY_W'(days_in_month(y, m));
            r.leap           = is_leap_year(y);
            r.valid_res      = 1'b1;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders; fields the command ignores get random values
    // ---------------------------------------------------------------
    task automatic queue_date(input int unsigned y, input int unsigned m, input int unsigned d);
        item_t it;
        it.cmd           = CMD_TO_JDN;
        it.year_in       = YEAR_W'(y);
        it.month_in      = MON_W'(m);
        it.day_in        = DAY_W'(d);
        it.day_number_in = JDN_W'($urandom);
        dates_to_send.push_back(it);
    endtask

    task automatic queue_day_number(input int unsigned jd);
        item_t it;
        it.cmd           = CMD_TO_DATE;
        it.year_in       = YEAR_W'($urandom);
        it.month_in      = MON_W'($urandom);
        it.day_in        = DAY_W'($urandom);
        it.day_number_in = JDN_W'(jd);
        dates_to_send.push_back(it);
    endtask

    // ---------------------------------------------------------------
    // Stimulus, end of test
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned     y, m, len;
        logic [63:0]     raw;
        item_t           it;

        // directed: range edges, reform date, leap rules, bad fields
        queue_date(0, 1, 1);
        queue_date(99, 12, 31);
        queue_date(0, 2, 29);
        queue_date(96, 2, 29);
        queue_date(100, 6, 15);
        queue_date(1751, 12, 31);
        queue_date(1752, 9, 13);
        queue_date(1752, 9, 14);
        queue_date(1752, 8, 31);
        queue_date(1752, 10, 1);
        queue_date(9999, 12, 31);
        queue_date(10000, 1, 1);
        queue_date(16383, 15, 31);
        queue_date(2000, 2, 29);
        queue_date(2004, 2, 29);
        queue_date(2023, 0, 10);
        queue_date(2023, 13, 10);
        queue_date(2023, 5, 0);
        queue_date(2023, 4, 31);
        queue_day_number(2361221);
        queue_day_number(2361222);
        queue_day_number(5373484);
        queue_day_number(5373485);
        queue_day_number(0);
        queue_day_number(8388607);

        // random: mostly well-formed dates and day numbers, some noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                begin
                    case ($urandom_range(0, 9))
                        0, 1:    y = $urandom_range(0, 99);
                        2:       y = 1752;
                        3:       y = 100 * $urandom_range(18, 99);
                        default: y = $urandom_range(1752, 9999);
                    endcase
                    m   = (y == 1752) ? $urandom_range(8, 12) : $urandom_range(1, 12);
                    len = days_in_month((y <= 99) ? y + 1900 : y, m);
                    if ($urandom_range(0, 5) == 0)
                        queue_date(y, m, $urandom_range(1, 31));
                    else
                        queue_date(y, m, $urandom_range(1, len));
                end
                8, 9, 10, 11, 12, 13, 14:
                    queue_day_number($urandom_range(2361222, 5373484));
                15:
                begin
                    if ($urandom_range(0, 1) == 0)
                        queue_day_number(2361222 + $urandom_range(0, 6) - 3);
                    else
                        queue_day_number(5373484 + $urandom_range(0, 6) - 3);
                end
                default:
                begin
                    raw = {$urandom, $urandom};
                    it  = raw[$bits(item_t)-1:0];
                    dates_to_send.push_back(it);
                end
            endcase
        end

        @(posedge rst_n);
        while (dates_to_send.size() != 0 || item_valid)
            @(posedge clk);
        while (awaited_conversions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // reset: asserted once at start
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Item driver: new transfer only after the last one was taken
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                item_valid <= 1'b0;
            end
            else if (dates_to_send.size() != 0)
            begin
                if (dates_to_send.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
                begin
                    // idle burst that starts with this cycle
                    send_gap = $urandom_range(0, 14);
                    item_valid <= 1'b0;
                end
                else
                begin
                    item_data  <= dates_to_send.pop_front();
                    item_valid <= 1'b1;
                end
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result stall bursts, independent of result_valid
    always @(negedge clk)
    begin
        if (recv_gap != 0)
        begin
            recv_gap = recv_gap - 1;
            result_stall <= 1'b1;
        end
        else if (rst_n && dates_to_send.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
        begin
            recv_gap = $urandom_range(0, 14);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor: predict on item transfer, check on result transfer
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        string   diffs;
        if (!rst_n)
            item_taken <= 1'b0;
        else
        begin
            item_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
                awaited_conversions.push_back(convert_calendar(item_data));
            if (result_valid && !result_stall)
            begin
                if (awaited_conversions.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: result with nothing pending: %p", $realtime, result_data);
                end
                else
                begin
                    want  = awaited_conversions.pop_front();
                    diffs = "";
                    if (result_data.day_number_out !== want.day_number_out)
                        diffs = {diffs, " day_number_out"};
                    if (result_data.year_out !== want.year_out)
                        diffs = {diffs, " year_out"};
                    if (result_data.month_out !== want.month_out)
                        diffs = {diffs, " month_out"};
                    if (result_data.day_out !== want.day_out)
                        diffs = {diffs, " day_out"};
                    if (result_data.weekday !== want.weekday)
                        diffs = {diffs, " weekday"};
                    if (result_data.month_length !== want.month_length)
                        diffs = {diffs, " month_length"};
                    if (result_data.leap !== want.leap)
                        diffs = {diffs, " leap"};
                    if (result_data.valid_res !== want.valid_res)
                        diffs = {diffs, " valid_res"};
                    if (diffs != "")
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("%0t: mismatch in%s\n  expected %p\n  actual   %p",
                                     $realtime, diffs, want, result_data);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

[sim.f]
+incdir+rtl
rtl/gjd_pkg.sv
rtl/gjd_pipe_ctrl.sv
rtl/gjd_date_to_jdn.sv
rtl/gjd_jdn_to_date.sv
rtl/gregorian_julian_day_converter_top.sv
verif/testbench.sv
